// ===== design/ckb_pkg.sv =====
// -----------------------------------------------------------------------------
// ckb_pkg: shared types and constants for the clipped keyed pixel blit
// Field widths, register indexes, reset values and the stage payload structs.
// -----------------------------------------------------------------------------
package ckb_pkg;

  // Fixed field widths
  localparam int SIZE_W    = 13;  // size and offset registers
  localparam int CNT_W     = 13;  // raster counters, always below a 13-bit size
  localparam int POS_W     = 16;  // signed destination coordinate
  localparam int IDX_W     = 24;  // destination pixel index
  localparam int PROD_W    = 2 * SIZE_W;  // row times destination width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = SIZE_W;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_WIDTH  = 3'd0,
    REG_DEST_HEIGHT = 3'd1,
    REG_SRC_WIDTH   = 3'd2,
    REG_SRC_HEIGHT  = 3'd3,
    REG_X_OFFSET    = 3'd4,
    REG_Y_OFFSET    = 3'd5,
    REG_KEY_MODE    = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [SIZE_W-1:0] RESET_DEST_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_DEST_HEIGHT = 13'd480;
  localparam logic [SIZE_W-1:0] RESET_SRC_WIDTH   = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_SRC_HEIGHT  = 13'd480;
  localparam logic [SIZE_W-1:0] RESET_OFFSET      = 13'd0;
  localparam logic              RESET_KEY_MODE    = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pixel_t;

  // Effective configuration, sizes already clamped
  typedef struct packed {
    logic [SIZE_W-1:0]        dest_width;
    logic [SIZE_W-1:0]        dest_height;
    logic [SIZE_W-1:0]        src_width;
    logic [SIZE_W-1:0]        src_height;
    logic signed [SIZE_W-1:0] x_offset;
    logic signed [SIZE_W-1:0] y_offset;
    logic                     key_mode;
  } cfg_t;

  // Input register contents
  typedef struct packed {
    pixel_t            pixel;
    logic [CNT_W-1:0]  column;
    logic [CNT_W-1:0]  row;
    logic              end_of_image;
  } s1_t;

  // Clip and multiply register contents
  typedef struct packed {
    pixel_t             pixel;
    logic               write_enable;
    logic               in_bounds;
    logic               end_of_image;
    logic [SIZE_W-1:0]  column;
    logic [PROD_W-1:0]  row_base;
  } s2_t;

endpackage

// ===== design/ckb_src_if.sv =====
// -----------------------------------------------------------------------------
// ckb_src_if: source pixel channel
// Valid/ready channel carrying one BGRA source pixel per request.
// -----------------------------------------------------------------------------
interface ckb_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_blue;
  logic [7:0] src_green;
  logic [7:0] src_red;
  logic [7:0] src_alpha;

  modport source (output valid, src_blue, src_green, src_red, src_alpha, input ready);
  modport sink   (input valid, src_blue, src_green, src_red, src_alpha, output ready);
endinterface

// ===== design/ckb_dst_if.sv =====
// -----------------------------------------------------------------------------
// ckb_dst_if: destination write channel
// Valid/ready channel carrying one destination write request per pixel.
// -----------------------------------------------------------------------------
interface ckb_dst_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [23:0] dest_pixel_index;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_alpha;
  logic        end_of_image;

  modport source (output valid, write_enable, dest_pixel_index, out_blue, out_green,
                  out_red, out_alpha, end_of_image, input ready);
  modport sink   (input valid, write_enable, dest_pixel_index, out_blue, out_green,
                  out_red, out_alpha, end_of_image, output ready);
endinterface

// ===== design/ckb_cfg_if.sv =====
// -----------------------------------------------------------------------------
// ckb_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// -----------------------------------------------------------------------------
interface ckb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/clipped_keyed_pixel_blit_core.sv =====
// -----------------------------------------------------------------------------
// clipped_keyed_pixel_blit_core: clipped, alpha-keyed pixel blit
// Takes source BGRA pixels in raster order, one per clock while the sink
// keeps up, and returns one destination write request per pixel, presented
// on the destination channel after passing, in order, through:
// an input register with the raster counters, a clip stage that also forms
// row times destination width in its single multiplier, and a result register
// that adds the column. The three stages each hold one pixel and advance
// independently, so a stalled sink only stops the pipeline once every stage
// is full. Clipped pixels come out with write_enable low, index zero and zero
// bytes; pixels dropped by the alpha key keep their index. Registers are
// written through the configuration channel and are meant to change only
// while no pixel is in flight.
// -----------------------------------------------------------------------------
module clipped_keyed_pixel_blit_core
  import ckb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk,
  input  logic      rst,
  ckb_src_if.sink   src,
  ckb_dst_if.source dst,
  ckb_cfg_if.sink   cfg
);

  cfg_t settings;
  logic s1_valid;
  s1_t  s1;
  logic s1_ready;
  logic s2_valid;
  s2_t  s2;
  logic s2_ready;

  ckb_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  ckb_input_stage u_input_stage (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .settings   (settings),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .down_ready (s1_ready)
  );

  ckb_clip_stage u_clip_stage (
    .clk        (clk),
    .rst        (rst),
    .settings   (settings),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_ready   (s1_ready),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .down_ready (s2_ready)
  );

  ckb_output_stage u_output_stage (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready),
    .dst      (dst)
  );

endmodule

// ===== design/ckb_cfg_regs.sv =====
// -----------------------------------------------------------------------------
// ckb_cfg_regs: configuration register file
// Holds the seven blit registers and presents them with sizes clamped to range.
// -----------------------------------------------------------------------------
module ckb_cfg_regs
  import ckb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk,
  input  logic      rst,
  ckb_cfg_if.sink   cfg,
  output cfg_t      settings
);

  localparam logic [SIZE_W+1:0] WIDTH_BOUND  = (SIZE_W + 2)'(MAX_WIDTH);
  localparam logic [SIZE_W+1:0] HEIGHT_BOUND = (SIZE_W + 2)'(MAX_HEIGHT);

  logic [SIZE_W-1:0] dest_width;
  logic [SIZE_W-1:0] dest_height;
  logic [SIZE_W-1:0] src_width;
  logic [SIZE_W-1:0] src_height;
  logic [SIZE_W-1:0] x_offset;
  logic [SIZE_W-1:0] y_offset;
  logic              key_mode;

  // Zero counts as one, anything above the bound saturates
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W+1:0] bound);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if ({2'b00, v} > bound) begin
      r = bound[SIZE_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg.ready = 1'b1;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width  <= RESET_DEST_WIDTH;
      dest_height <= RESET_DEST_HEIGHT;
      src_width   <= RESET_SRC_WIDTH;
      src_height  <= RESET_SRC_HEIGHT;
      x_offset    <= RESET_OFFSET;
      y_offset    <= RESET_OFFSET;
      key_mode    <= RESET_KEY_MODE;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_DEST_WIDTH:  dest_width  <= cfg.data;
        REG_DEST_HEIGHT: dest_height <= cfg.data;
        REG_SRC_WIDTH:   src_width   <= cfg.data;
        REG_SRC_HEIGHT:  src_height  <= cfg.data;
        REG_X_OFFSET:    x_offset    <= cfg.data;
        REG_Y_OFFSET:    y_offset    <= cfg.data;
        REG_KEY_MODE:    key_mode    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Present effective values
  always_comb begin
    settings.dest_width  = clamp_size(dest_width, WIDTH_BOUND);
    settings.dest_height = clamp_size(dest_height, HEIGHT_BOUND);
    settings.src_width   = clamp_size(src_width, WIDTH_BOUND);
    settings.src_height  = clamp_size(src_height, HEIGHT_BOUND);
    settings.x_offset    = signed'(x_offset);
    settings.y_offset    = signed'(y_offset);
    settings.key_mode    = key_mode;
  end

endmodule

// ===== design/ckb_input_stage.sv =====
// -----------------------------------------------------------------------------
// ckb_input_stage: input register and raster counters
// Captures each source pixel with its source position and advances the scan.
// -----------------------------------------------------------------------------
module ckb_input_stage
  import ckb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  ckb_src_if.sink  src,
  input  cfg_t     settings,
  output logic     s1_valid,
  output s1_t      s1,
  input  logic     down_ready
);

  logic [CNT_W-1:0] column;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] column_next;
  logic [CNT_W-1:0] row_next;
  logic [CNT_W:0]   column_plus;
  logic [CNT_W:0]   row_plus;
  logic             column_wrap;
  logic             row_wrap;
  logic             accept;

  assign src.ready = !s1_valid || down_ready;
  assign accept    = src.valid && src.ready;

  // Work out the next raster position
  always_comb begin
    column_plus = {1'b0, column} + (CNT_W + 1)'(1);
    row_plus    = {1'b0, row} + (CNT_W + 1)'(1);
    column_wrap = column_plus >= {1'b0, settings.src_width};
    row_wrap    = row_plus >= {1'b0, settings.src_height};
    column_next = column_wrap ? '0 : column_plus[CNT_W-1:0];
    if (column_wrap) begin
      row_next = row_wrap ? '0 : row_plus[CNT_W-1:0];
    end else begin
      row_next = row;
    end
  end

  // Advance the counters on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      column <= column_next;
      row    <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src.ready) begin
      s1_valid <= src.valid;
    end
  end

  // Capture the pixel with its position
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pixel.blue     <= src.src_blue;
      s1.pixel.green    <= src.src_green;
      s1.pixel.red      <= src.src_red;
      s1.pixel.alpha    <= src.src_alpha;
      s1.column         <= column;
      s1.row            <= row;
      s1.end_of_image   <= column_wrap && row_wrap;
    end
  end

endmodule

// ===== design/ckb_clip_stage.sv =====
// -----------------------------------------------------------------------------
// ckb_clip_stage: destination placement, clipping and key test
// Offsets the source position, clips it, applies the alpha key and forms the
// row base of the destination index.
// -----------------------------------------------------------------------------
module ckb_clip_stage
  import ckb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  settings,
  input  logic  s1_valid,
  input  s1_t   s1,
  output logic  s1_ready,
  output logic  s2_valid,
  output s2_t   s2,
  input  logic  down_ready
);

  logic [POS_W-1:0]  dest_col;
  logic [POS_W-1:0]  dest_row;
  logic              in_bounds;
  logic              write_enable;
  logic [SIZE_W-1:0] col_short;
  logic [SIZE_W-1:0] row_short;
  logic [PROD_W-1:0] row_base;

  assign s1_ready = !s2_valid || down_ready;

  // Place, clip and key
  always_comb begin
    dest_col = {{(POS_W - CNT_W){1'b0}}, s1.column}
             + {{(POS_W - SIZE_W){settings.x_offset[SIZE_W-1]}}, settings.x_offset};
    dest_row = {{(POS_W - CNT_W){1'b0}}, s1.row}
             + {{(POS_W - SIZE_W){settings.y_offset[SIZE_W-1]}}, settings.y_offset};
    in_bounds = !dest_col[POS_W-1] && !dest_row[POS_W-1]
             && (dest_col[POS_W-2:0] < (POS_W - 1)'(settings.dest_width))
             && (dest_row[POS_W-2:0] < (POS_W - 1)'(settings.dest_height));
    write_enable = in_bounds && (!settings.key_mode || s1.pixel.alpha == ALPHA_OPAQUE);
    col_short = dest_col[SIZE_W-1:0];
    row_short = dest_row[SIZE_W-1:0];
    row_base  = PROD_W'(row_short) * PROD_W'(settings.dest_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // Hold the clip result and row base; zero the bytes of a dropped pixel
  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2.pixel        <= write_enable ? s1.pixel : '0;
      s2.write_enable <= write_enable;
      s2.in_bounds    <= in_bounds;
      s2.end_of_image <= s1.end_of_image;
      s2.column       <= col_short;
      s2.row_base     <= row_base;
    end
  end

endmodule

// ===== design/ckb_output_stage.sv =====
// -----------------------------------------------------------------------------
// ckb_output_stage: index add and result register
// Adds the column to the row base and holds the write request for the sink.
// -----------------------------------------------------------------------------
module ckb_output_stage
  import ckb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s2_valid,
  input  s2_t       s2,
  output logic      s2_ready,
  ckb_dst_if.source dst
);

  logic              out_valid;
  logic              write_enable;
  logic [IDX_W-1:0]  pixel_index;
  logic [IDX_W-1:0]  pixel_index_next;
  pixel_t            pixel;
  logic              end_of_image;
  logic [PROD_W-1:0] index_sum;

  assign s2_ready = !out_valid || dst.ready;

  // Clipped pixels report index zero
  always_comb begin
    index_sum        = s2.row_base + PROD_W'(s2.column);
    pixel_index_next = s2.in_bounds ? index_sum[IDX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s2_valid;
    end
  end

  // Load the result when the sink side frees up
  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      write_enable <= s2.write_enable;
      pixel_index  <= pixel_index_next;
      pixel        <= s2.pixel;
      end_of_image <= s2.end_of_image;
    end
  end

  assign dst.valid            = out_valid;
  assign dst.write_enable     = write_enable;
  assign dst.dest_pixel_index = pixel_index;
  assign dst.out_blue         = pixel.blue;
  assign dst.out_green        = pixel.green;
  assign dst.out_red          = pixel.red;
  assign dst.out_alpha        = pixel.alpha;
  assign dst.end_of_image     = end_of_image;

endmodule

// ===== design/ckb_checker.sv =====
// -----------------------------------------------------------------------------
// ckb_checker: port-level checks for the pixel blit core
// Watches the source and destination channels and flags flow or payload slips.
// -----------------------------------------------------------------------------
module ckb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_enable,
  input logic [23:0] dest_pixel_index,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_green,
  input logic [7:0]  out_red,
  input logic [7:0]  out_alpha,
  input logic        end_of_image
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A free result register frees every stage behind it
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("source stalled while the result side is free");

  // A pixel that is not written carries zero bytes
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |->
      (out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0 && out_alpha == 8'd0))
    else $error("dropped pixel carries color bytes");

  // A stalled request holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(dest_pixel_index) && $stable(write_enable)
       && $stable(end_of_image)))
    else $error("stalled write request changed");

endmodule

bind clipped_keyed_pixel_blit_core ckb_checker u_ckb_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (src.ready),
  .out_valid        (dst.valid),
  .out_ready        (dst.ready),
  .write_enable     (dst.write_enable),
  .dest_pixel_index (dst.dest_pixel_index),
  .out_blue         (dst.out_blue),
  .out_green        (dst.out_green),
  .out_red          (dst.out_red),
  .out_alpha        (dst.out_alpha),
  .end_of_image     (dst.end_of_image)
);
